### hdl/dlog_pkg.sv
// shared types and constants for the discrete log engine
package dlog_pkg;

    localparam int MOD_BITS   = 24;
    localparam int EXP_BITS   = 25;
    localparam int TAB_BITS   = 13;
    localparam int TAB_DEPTH  = 1 << TAB_BITS;
    localparam int IDX_BITS   = 13;
    localparam int CNT_BITS   = 5;
    localparam int SQRT_BITS  = 13;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_CHECK1,
        ST_POW_MUL,
        ST_POW_RED,
        ST_GCD_START,
        ST_GCD_STEP,
        ST_TGT_CHK,
        ST_DIV_M,
        ST_DIV_T,
        ST_DIV_A,
        ST_SCALE_MUL,
        ST_SCALE_RED,
        ST_SQRT,
        ST_CLEAR,
        ST_BABY_MUL,
        ST_BABY_RED,
        ST_KEY_MUL,
        ST_KEY_RED,
        ST_PUT_RD,
        ST_PUT_CHK,
        ST_G_MUL,
        ST_G_RED,
        ST_GET_RD,
        ST_GET_CHK,
        ST_GIANT_MUL,
        ST_GIANT_RED,
        ST_DONE
    } state_t;

    // request to the shared divider
    typedef struct packed {
        logic                  go;
        logic [2*MOD_BITS-1:0] num;
        logic [MOD_BITS-1:0]   den;
    } div_req_t;

    // divider response
    typedef struct packed {
        logic                  done;
        logic [2*MOD_BITS-1:0] quo;
        logic [MOD_BITS-1:0]   rem;
    } div_rsp_t;

endpackage

### hdl/dlog_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module dlog_divider
    import dlog_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int NB = 2 * MOD_BITS;

    logic [NB-1:0]       quo_reg;
    logic [MOD_BITS:0]   rem_reg;
    logic [MOD_BITS-1:0] den_reg;
    logic [5:0]          cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [MOD_BITS+1:0] trial;
    logic [MOD_BITS:0]   shifted;

    // shift in next numerator bit and try subtraction
    always_comb
    begin
        shifted = {rem_reg[MOD_BITS-1:0], quo_reg[NB-1]};
        trial   = {1'b0, shifted} - {2'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(NB);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            quo_reg <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (!trial[MOD_BITS+1])
            begin
                rem_reg <= trial[MOD_BITS:0];
                quo_reg <= {quo_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[NB-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg[MOD_BITS-1:0];

endmodule

### hdl/dlog_table.sv
// key/index hash store with per-entry valid bits and a clearing sweep
module dlog_table
    import dlog_pkg::*;
(
    input  logic                clk,
    input  logic                clr,
    input  logic [TAB_BITS-1:0] addr,
    input  logic                rd,
    input  logic                wr,
    input  logic [MOD_BITS-1:0] wr_key,
    input  logic [IDX_BITS-1:0] wr_idx,
    output logic                rd_valid,
    output logic [MOD_BITS-1:0] rd_key,
    output logic [IDX_BITS-1:0] rd_idx
);

    logic [MOD_BITS-1:0] key_mem [TAB_DEPTH];
    logic [IDX_BITS-1:0] idx_mem [TAB_DEPTH];
    logic                vld_mem [TAB_DEPTH];

    // valid bit store, cleared one entry a cycle by the sequencer
    always_ff @(posedge clk)
    begin
        if (clr)
            vld_mem[addr] <= 1'b0;
        else if (wr)
            vld_mem[addr] <= 1'b1;
        if (rd)
            rd_valid <= vld_mem[addr];
    end

    // payload stores
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            key_mem[addr] <= wr_key;
            idx_mem[addr] <= wr_idx;
        end
        if (rd)
        begin
            rd_key <= key_mem[addr];
            rd_idx <= idx_mem[addr];
        end
    end

endmodule

### hdl/discrete_log_bsgs_engine.sv
// run time is data dependent; each divide goes through the shared 48/24-bit serial
// divider, and a query may run the gcd stage, an 8192-entry clearing sweep of the table,
// the baby steps and then the giant steps, each with its table probes
// one query at a time: busy is high from the accepting edge until the result strobe
// reset: asynchronous active low, returns the sequencer to idle
// the receiver cannot stall: done pulses for one cycle with found and exponent
module discrete_log_bsgs_engine
    import dlog_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MOD_BITS-1:0] base,
    input  logic [MOD_BITS-1:0] target,
    input  logic [MOD_BITS-1:0] modulus,
    output logic                done,
    output logic                found,
    output logic [EXP_BITS-1:0] exponent
);

    state_t state_reg, state_next;

    logic [MOD_BITS-1:0]   a_reg, b_reg, m_reg, wm_reg, wt_reg, k_reg, rp_reg, d_reg;
    logic [MOD_BITS-1:0]   ga_reg, gb_reg, step_reg, g_reg, lim_reg;
    logic [MOD_BITS-1:0]   key_reg;
    logic [2*MOD_BITS-1:0] prod_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [SQRT_BITS:0]    i_reg;
    logic [TAB_BITS:0]     ptr_reg;
    logic [TAB_BITS-1:0]   addr_reg;
    logic [SQRT_BITS:0]    sq_reg;
    logic [4:0]            sqb_reg;
    logic                  ok_reg;
    logic [EXP_BITS-1:0]   x_reg;
    logic                  wait_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    logic                rd_valid;
    logic [MOD_BITS-1:0] rd_key;
    logic [IDX_BITS-1:0] rd_idx;
    logic                t_clr, t_rd, t_wr;

    dlog_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    dlog_table u_tab (
        .clk(clk), .clr(t_clr), .addr(addr_reg),
        .rd(t_rd), .wr(t_wr), .wr_key(key_reg), .wr_idx(i_reg[IDX_BITS-1:0]),
        .rd_valid(rd_valid), .rd_key(rd_key), .rd_idx(rd_idx)
    );

    logic [2*SQRT_BITS+1:0] sq_try;
    logic [SQRT_BITS:0]     sq_cand;
    logic [SQRT_BITS:0]     sq_fin;
    logic [2*SQRT_BITS+1:0] sq_fin2;
    always_comb
    begin
        sq_cand = sq_reg | ((SQRT_BITS+1)'(1) << sqb_reg);
        sq_try  = sq_cand * sq_cand;
        sq_fin2 = sq_reg * sq_reg;
        sq_fin  = (sq_fin2 < (2*SQRT_BITS+2)'(wm_reg)) ? sq_reg + 1'b1 : sq_reg;
    end

    // divider issue: one request per divide, in the first cycle of a divide state or of each gcd step
    logic div_state;
    always_comb
    begin
        div_state = (state_reg == ST_RED_A) || (state_reg == ST_RED_B) ||
                    (state_reg == ST_POW_RED) ||
                    ((state_reg == ST_GCD_STEP) && (gb_reg != '0)) ||
                    (state_reg == ST_TGT_CHK) || (state_reg == ST_DIV_M) ||
                    (state_reg == ST_DIV_T) || (state_reg == ST_DIV_A) ||
                    (state_reg == ST_SCALE_RED) || (state_reg == ST_BABY_RED) ||
                    (state_reg == ST_KEY_RED) || (state_reg == ST_G_RED) ||
                    (state_reg == ST_GIANT_RED);
        dreq.go  = div_state && !wait_reg;
        dreq.num = '0;
        dreq.den = wm_reg;
        unique case (state_reg)
            ST_RED_A:     begin dreq.num = {24'd0, a_reg}; dreq.den = m_reg; end
            ST_RED_B:     begin dreq.num = {24'd0, b_reg}; dreq.den = m_reg; end
            ST_POW_RED:   begin dreq.num = prod_reg; dreq.den = m_reg; end
            ST_GCD_STEP:  begin dreq.num = {24'd0, ga_reg}; dreq.den = gb_reg; end
            ST_TGT_CHK:   begin dreq.num = {24'd0, wt_reg}; dreq.den = d_reg; end
            ST_DIV_M:     begin dreq.num = {24'd0, wm_reg}; dreq.den = d_reg; end
            ST_DIV_T:     begin dreq.num = {24'd0, wt_reg}; dreq.den = d_reg; end
            ST_DIV_A:     begin dreq.num = {24'd0, a_reg}; dreq.den = d_reg; end
            ST_SCALE_RED, ST_BABY_RED, ST_KEY_RED, ST_G_RED, ST_GIANT_RED:
                          begin dreq.num = prod_reg; dreq.den = wm_reg; end
            default:      begin dreq.num = '0; end
        endcase
    end

    logic go_ok;
    assign go_ok = wait_reg && drsp.done;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (start) state_next = (modulus == '0) ? ST_DONE : ST_RED_A;
            ST_RED_A:     if (go_ok) state_next = ST_RED_B;
            ST_RED_B:     if (go_ok) state_next = ST_CHECK1;
            ST_CHECK1:    state_next = (b_reg == 24'd1 || m_reg == 24'd1 || rp_reg == b_reg)
                                       ? ST_DONE : ST_POW_MUL;
            ST_POW_MUL:   state_next = ST_POW_RED;
            ST_POW_RED:   if (go_ok) state_next = ST_GCD_START;
            ST_GCD_START: state_next = ST_GCD_STEP;
            ST_GCD_STEP:  if (gb_reg == '0) state_next = ST_TGT_CHK;
            ST_TGT_CHK:   if (go_ok) state_next = (drsp.rem != '0) ? ST_DONE :
                                       (d_reg == 24'd1) ? ST_SQRT : ST_DIV_M;
            ST_DIV_M:     if (go_ok) state_next = ST_DIV_T;
            ST_DIV_T:     if (go_ok) state_next = ST_DIV_A;
            ST_DIV_A:     if (go_ok) state_next = ST_SCALE_MUL;
            ST_SCALE_MUL: state_next = ST_SCALE_RED;
            ST_SCALE_RED: if (go_ok) state_next = ST_CHECK1;
            ST_SQRT:      if (sqb_reg == 5'd0) state_next = ST_CLEAR;
            ST_CLEAR:     if (ptr_reg[TAB_BITS]) state_next = ST_BABY_MUL;
            ST_BABY_MUL:  state_next = ST_BABY_RED;
            ST_BABY_RED:  if (go_ok) state_next = ST_KEY_MUL;
            ST_KEY_MUL:   state_next = ST_KEY_RED;
            ST_KEY_RED:   if (go_ok) state_next = ST_PUT_RD;
            ST_PUT_RD:    state_next = ST_PUT_CHK;
            ST_PUT_CHK:   if (!rd_valid || rd_key == key_reg)
                              state_next = ({10'd0, i_reg} == lim_reg) ? ST_G_MUL
                                                                       : ST_BABY_MUL;
                          else state_next = ST_PUT_RD;
            ST_G_MUL:     state_next = ST_G_RED;
            ST_G_RED:     if (go_ok) state_next = ST_GET_RD;
            ST_GET_RD:    state_next = ST_GET_CHK;
            ST_GET_CHK:   if (!rd_valid)
                              state_next = ({10'd0, i_reg} == lim_reg) ? ST_DONE
                                                                       : ST_GIANT_MUL;
                          else if (rd_key == g_reg) state_next = ST_DONE;
                          else state_next = ST_GET_RD;
            ST_GIANT_MUL: state_next = ST_GIANT_RED;
            ST_GIANT_RED: if (go_ok) state_next = ST_GET_RD;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // table strobes
    always_comb
    begin
        t_clr = (state_reg == ST_CLEAR) && !ptr_reg[TAB_BITS];
        t_rd  = (state_reg == ST_PUT_RD) || (state_reg == ST_GET_RD);
        t_wr  = (state_reg == ST_PUT_CHK) && (!rd_valid || rd_key == key_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wait_reg  <= 1'b0;
            done      <= 1'b0;
            found     <= 1'b0;
            exponent  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (dreq.go)
                wait_reg <= 1'b1;
            else if (drsp.done)
                wait_reg <= 1'b0;
            done <= (state_reg == ST_DONE);
            if (state_reg == ST_DONE)
            begin
                found    <= ok_reg;
                exponent <= ok_reg ? x_reg : '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                a_reg <= base; b_reg <= target; m_reg <= modulus;
                ok_reg <= 1'b0; x_reg <= '0;
            end
            ST_RED_A: if (go_ok) a_reg <= drsp.rem;
            ST_RED_B:
                if (go_ok)
                begin
                    b_reg <= drsp.rem; wm_reg <= m_reg; wt_reg <= drsp.rem;
                    k_reg <= 24'd1; cnt_reg <= '0; rp_reg <= 24'd1;
                end
            ST_CHECK1:
            begin
                if (b_reg == 24'd1 || m_reg == 24'd1)
                begin
                    ok_reg <= 1'b1; x_reg <= '0;
                end
                else if (rp_reg == b_reg)
                begin
                    ok_reg <= 1'b1; x_reg <= EXP_BITS'(cnt_reg);
                end
            end
            ST_POW_MUL:   prod_reg <= rp_reg * a_reg;
            ST_POW_RED:   if (go_ok) rp_reg <= drsp.rem;
            ST_GCD_START: begin ga_reg <= a_reg; gb_reg <= wm_reg; end
            ST_GCD_STEP:
                if (gb_reg == '0) d_reg <= ga_reg;
                else if (go_ok) begin ga_reg <= gb_reg; gb_reg <= drsp.rem; end
            ST_TGT_CHK:
                if (go_ok && drsp.rem == '0 && d_reg == 24'd1)
                begin
                    sq_reg <= '0; sqb_reg <= 5'(SQRT_BITS - 1);
                end
            ST_DIV_M:     if (go_ok) wm_reg <= drsp.quo[MOD_BITS-1:0];
            ST_DIV_T:     if (go_ok) wt_reg <= drsp.quo[MOD_BITS-1:0];
            ST_DIV_A:     if (go_ok) prod_reg <= k_reg * drsp.quo[MOD_BITS-1:0];
            ST_SCALE_MUL: ;
            ST_SCALE_RED:
                if (go_ok) begin k_reg <= drsp.rem; cnt_reg <= cnt_reg + 1'b1; end
            ST_SQRT:
            begin
                if (sq_try <= (2*SQRT_BITS+2)'(wm_reg)) sq_reg <= sq_cand;
                if (sqb_reg == 5'd0)
                begin
                    lim_reg <= '0; ptr_reg <= '0; addr_reg <= '0;
                end
                else sqb_reg <= sqb_reg - 1'b1;
            end
            ST_CLEAR:
            begin
                if (ptr_reg == '0) lim_reg <= MOD_BITS'(sq_fin);
                ptr_reg  <= ptr_reg + 1'b1;
                addr_reg <= ptr_reg[TAB_BITS-1:0] + 1'b1;
                step_reg <= 24'd1; i_reg <= '0;
            end
            ST_BABY_MUL:  begin prod_reg <= step_reg * a_reg; i_reg <= i_reg + 1'b1; end
            ST_BABY_RED:  if (go_ok) step_reg <= drsp.rem;
            ST_KEY_MUL:   prod_reg <= wt_reg * step_reg;
            ST_KEY_RED:
                if (go_ok)
                begin
                    key_reg <= drsp.rem; addr_reg <= drsp.rem[TAB_BITS-1:0];
                end
            ST_PUT_RD:    ;
            ST_PUT_CHK:
                if (!rd_valid || rd_key == key_reg)
                begin
                    if ({10'd0, i_reg} == lim_reg) prod_reg <= step_reg * k_reg;
                end
                else addr_reg <= addr_reg + 1'b1;
            ST_G_MUL:     i_reg <= 14'd1;
            ST_G_RED:
                if (go_ok)
                begin
                    g_reg <= drsp.rem; addr_reg <= drsp.rem[TAB_BITS-1:0];
                end
            ST_GET_RD:    ;
            ST_GET_CHK:
                if (rd_valid && rd_key == g_reg)
                begin
                    ok_reg <= 1'b1;
                    x_reg  <= EXP_BITS'(i_reg) * EXP_BITS'(lim_reg[SQRT_BITS:0])
                              - EXP_BITS'(rd_idx) + EXP_BITS'(cnt_reg);
                end
                else if (rd_valid)
                    addr_reg <= addr_reg + 1'b1;
                else if ({10'd0, i_reg} != lim_reg)
                    prod_reg <= g_reg * step_reg;
            ST_GIANT_MUL: i_reg <= i_reg + 1'b1;
            ST_GIANT_RED:
                if (go_ok)
                begin
                    g_reg <= drsp.rem; addr_reg <= drsp.rem[TAB_BITS-1:0];
                end
            ST_DONE:      ;
            default:      ;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### hdl/dlog_checker.sv
// port-level checks for the discrete log engine
module dlog_checker
    import dlog_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic                found,
    input logic [EXP_BITS-1:0] exponent
);

    // a result strobe closes a transaction that was running
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    // accepted transaction raises busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised");

    // no-solution reports a zero exponent
    a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (exponent == '0))
        else $error("exponent not zero");

    // strobe is a single pulse
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held");

endmodule

bind discrete_log_bsgs_engine dlog_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .found(found), .exponent(exponent)
);
